### hdl/blocking_mean_std_error_core_macros.svh
// Assertion helpers shared by the checker
`ifndef BLOCKING_MEAN_STD_ERROR_CORE_MACROS_SVH
`define BLOCKING_MEAN_STD_ERROR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the block clock outside reset
`define BMSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bmse check failed");

// Next-cycle implication, sampled on the block clock outside reset
`define BMSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bmse check failed");

`endif

### hdl/bmse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bmse_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int ACC_W      = 48;
    localparam int SQ_W       = 64;
    localparam int SIZE_W     = 16;
    localparam int MAX_BLOCKS = 65536;
    localparam int BLK_W      = $clog2(MAX_BLOCKS + 1);
    localparam int DIVR_W     = 17;
    localparam int STD_W      = 31;

    // Divider operand selection
    localparam logic [1:0] SEL_BLOCK = 2'd0;
    localparam logic [1:0] SEL_MEAN  = 2'd1;
    localparam logic [1:0] SEL_SQ    = 2'd2;
    localparam logic [1:0] SEL_VAR   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOBLK = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       div_start;
        logic       div_take;
        logic [1:0] sel;
        logic       mul;
        logic       blk_acc;
        logic       sqrt_start;
        logic       sqrt_take;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic last;
        logic div_done;
        logic sqrt_done;
        logic no_blocks;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

### hdl/bmse_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bmse_div
    import bmse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SQ_W-1:0]   i_dividend,
    input  wire logic [DIVR_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [SQ_W-1:0]        o_quotient
);

    localparam int CNT_W = $clog2(SQ_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SQ_W-1:0]   r_q;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_d;
    logic [DIVR_W:0]   w_trial;
    logic              w_ge;

    // Restoring step: one quotient bit a cycle
    assign w_trial = {r_rem, r_q[SQ_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Hold operands and shift the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[SQ_W-2:0], w_ge};
            r_rem <= w_ge ? DIVR_W'(w_trial - {1'b0, r_d}) : w_trial[DIVR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

### hdl/bmse_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module bmse_sqrt
    import bmse_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [SQ_W-1:0] i_radicand,
    output logic                 o_done,
    output logic [SQ_W/2-1:0]    o_root
);

    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] r_v;
    logic [SQ_W-1:0] r_r;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W:0]   w_sum;
    logic            w_ge;

    // One result bit a cycle
    assign w_sum = {1'b0, r_r} + {1'b0, r_bit};
    assign w_ge  = {1'b0, r_v} >= w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_bit == SQ_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_radicand;
            r_r   <= '0;
            r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (r_busy) begin
            if (w_ge) begin
                r_v <= r_v - w_sum[SQ_W-1:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SQ_W/2-1:0];

endmodule
`default_nettype wire

### hdl/bmse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bmse_ctrl
    import bmse_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_last,
    input  wire t_stat i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BSTART = 4'd1;
    localparam logic [3:0] S_BDIV   = 4'd2;
    localparam logic [3:0] S_BMUL   = 4'd3;
    localparam logic [3:0] S_BACC   = 4'd4;
    localparam logic [3:0] S_FIN    = 4'd5;
    localparam logic [3:0] S_EDIV   = 4'd6;
    localparam logic [3:0] S_EMUL   = 4'd7;
    localparam logic [3:0] S_QDIV   = 4'd8;
    localparam logic [3:0] S_VSTART = 4'd9;
    localparam logic [3:0] S_VDIV   = 4'd10;
    localparam logic [3:0] S_RSTART = 4'd11;
    localparam logic [3:0] S_RWAIT  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Accept samples, sequence block close and final statistics, and load the result
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.close) begin
                        n_state = S_BSTART;
                    end else if (i_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_BSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.sel       = SEL_BLOCK;
                n_state         = S_BDIV;
            end
            S_BDIV: begin
                o_cmd.sel = SEL_BLOCK;
                if (i_stat.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_BMUL;
                end
            end
            S_BMUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_BACC;
            end
            S_BACC: begin
                o_cmd.blk_acc = 1'b1;
                n_state       = i_stat.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (i_stat.no_blocks) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.sel       = SEL_MEAN;
                    n_state         = S_EDIV;
                end
            end
            S_EDIV: begin
                o_cmd.sel = SEL_MEAN;
                if (i_stat.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_EMUL;
                end
            end
            S_EMUL: begin
                o_cmd.mul       = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.sel       = SEL_SQ;
                n_state         = S_QDIV;
            end
            S_QDIV: begin
                o_cmd.sel = SEL_SQ;
                if (i_stat.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_VSTART;
                end
            end
            S_VSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.sel       = SEL_VAR;
                n_state         = S_VDIV;
            end
            S_VDIV: begin
                o_cmd.sel = SEL_VAR;
                if (i_stat.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_RSTART;
                end
            end
            S_RSTART: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.sqrt_take = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

### hdl/bmse_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module bmse_dp
    import bmse_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_last,
    input  wire logic [SIZE_W-1:0]   i_grp_len,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [SAMPLE_W-1:0]      o_mean,
    output logic [STD_W-1:0]         o_std_error,
    output logic [BLK_W-1:0]         o_blocks_used,
    output logic [1:0]               o_status
);

    localparam logic [ACC_W-1:0]    ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]    ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]     V_MAX   = {{(SQ_W-ACC_W){1'b0}}, {ACC_W{1'b1}}};
    localparam logic [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic                flag;
        logic [SAMPLE_W-1:0] m;
        logic [SAMPLE_W-1:0] mag;
    } t_clamp;

    // Signed quotient from magnitude, clamped to the output range
    function automatic t_clamp f_clamp(input logic [SQ_W-1:0] q, input logic neg);
        t_clamp c;
        c.flag = 1'b0;
        if (!neg && (q > {{(SQ_W-SAMPLE_W){1'b0}}, OUT_MAX})) begin
            c.flag = 1'b1;
            c.m    = OUT_MAX;
            c.mag  = OUT_MAX;
        end else if (neg && (q > {{(SQ_W-SAMPLE_W){1'b0}}, OUT_MIN})) begin
            c.flag = 1'b1;
            c.m    = OUT_MIN;
            c.mag  = OUT_MIN;
        end else begin
            c.mag = q[SAMPLE_W-1:0];
            c.m   = neg ? (~q[SAMPLE_W-1:0] + 1'b1) : q[SAMPLE_W-1:0];
        end
        return c;
    endfunction

    // Series state
    logic [SIZE_W-1:0]   r_fill;
    logic [ACC_W-1:0]    r_bsum;
    logic [BLK_W-1:0]    r_bcount;
    logic [ACC_W-1:0]    r_msum;
    logic [SQ_W-1:0]     r_ssum;
    logic                r_ovf;
    logic                r_last;
    // Working registers
    logic [SAMPLE_W-1:0] r_m;
    logic [SAMPLE_W-1:0] r_mag;
    logic [SQ_W-1:0]     r_prod;
    logic [SQ_W-1:0]     r_acc;
    logic                r_neg;
    logic [STD_W-1:0]    r_std;
    // Result register
    logic                r_ovalid;
    logic [SAMPLE_W-1:0] r_omean;
    logic [STD_W-1:0]    r_ostd;
    logic [BLK_W-1:0]    r_oblk;
    logic [1:0]          r_ostat;

    logic [SIZE_W-1:0]   w_size;
    logic                w_close;
    logic [ACC_W-1:0]    w_samp;
    logic [ACC_W:0]      w_badd;
    logic                w_bovf;
    logic [ACC_W-1:0]    w_bsat;
    logic [ACC_W:0]      w_madd;
    logic                w_movf;
    logic [ACC_W-1:0]    w_msat;
    logic [SQ_W:0]       w_sadd;
    logic [ACC_W-1:0]    w_babs;
    logic [ACC_W-1:0]    w_mabs;
    logic [SQ_W-1:0]     w_dividend;
    logic [DIVR_W-1:0]   w_divisor;
    logic                w_neg;
    logic                w_div_done;
    logic [SQ_W-1:0]     w_quot;
    logic                w_sqrt_done;
    logic [SQ_W/2-1:0]   w_root;
    logic [SQ_W-1:0]     w_esq;
    t_clamp              w_clamp;

    // Block size of zero counts as one
    assign w_size  = (i_grp_len == '0) ? SIZE_W'(1) : i_grp_len;
    assign w_close = ({1'b0, r_fill} + 1'b1) >= {1'b0, w_size};

    // Saturating block sum
    assign w_samp = {{(ACC_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
    assign w_badd = {r_bsum[ACC_W-1], r_bsum} + {w_samp[ACC_W-1], w_samp};
    assign w_bovf = w_badd[ACC_W] ^ w_badd[ACC_W-1];
    assign w_bsat = w_bovf ? (w_badd[ACC_W] ? ACC_MIN : ACC_MAX) : w_badd[ACC_W-1:0];

    // Saturating sum of block means and of squares
    assign w_madd = {r_msum[ACC_W-1], r_msum}
                  + {{(ACC_W-SAMPLE_W+1){r_m[SAMPLE_W-1]}}, r_m};
    assign w_movf = w_madd[ACC_W] ^ w_madd[ACC_W-1];
    assign w_msat = w_movf ? (w_madd[ACC_W] ? ACC_MIN : ACC_MAX) : w_madd[ACC_W-1:0];
    assign w_sadd = {1'b0, r_ssum} + {17'd0, r_prod[SQ_W-1:16]};

    assign w_babs = r_bsum[ACC_W-1] ? (~r_bsum + 1'b1) : r_bsum;
    assign w_mabs = r_msum[ACC_W-1] ? (~r_msum + 1'b1) : r_msum;
    assign w_esq  = {16'd0, r_prod[SQ_W-1:16]};
    assign w_clamp = f_clamp(w_quot, r_neg);

    // Pick divider operands
    always_comb begin
        case (i_cmd.sel)
            SEL_BLOCK: begin
                w_dividend = {{(SQ_W-ACC_W){1'b0}}, w_babs};
                w_divisor  = {1'b0, r_fill};
                w_neg      = r_bsum[ACC_W-1];
            end
            SEL_MEAN: begin
                w_dividend = {{(SQ_W-ACC_W){1'b0}}, w_mabs};
                w_divisor  = r_bcount;
                w_neg      = r_msum[ACC_W-1];
            end
            SEL_SQ: begin
                w_dividend = r_ssum;
                w_divisor  = r_bcount;
                w_neg      = 1'b0;
            end
            default: begin
                w_dividend = r_acc;
                w_divisor  = r_bcount;
                w_neg      = 1'b0;
            end
        endcase
    end

    bmse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    bmse_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand ({r_acc[ACC_W-1:0], 16'd0}),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // Update series state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_bsum   <= '0;
            r_bcount <= '0;
            r_msum   <= '0;
            r_ssum   <= '0;
            r_ovf    <= 1'b0;
            r_last   <= 1'b0;
        end else if (i_cmd.accept) begin
            r_bsum <= w_bsat;
            r_fill <= r_fill + 1'b1;
            r_last <= i_last;
            if (w_bovf) begin
                r_ovf <= 1'b1;
            end
        end else if (i_cmd.div_take && (i_cmd.sel == SEL_BLOCK || i_cmd.sel == SEL_MEAN)) begin
            if (w_clamp.flag) begin
                r_ovf <= 1'b1;
            end
        end else if (i_cmd.blk_acc) begin
            r_fill <= '0;
            r_bsum <= '0;
            if (r_bcount >= BLK_W'(MAX_BLOCKS)) begin
                r_ovf <= 1'b1;
            end else begin
                r_bcount <= r_bcount + 1'b1;
                r_msum   <= w_msat;
                if (w_sadd[SQ_W]) begin
                    r_ssum <= '1;
                end else begin
                    r_ssum <= w_sadd[SQ_W-1:0];
                end
                if (w_movf || w_sadd[SQ_W]) begin
                    r_ovf <= 1'b1;
                end
            end
        end else if (i_cmd.out_load) begin
            r_fill   <= '0;
            r_bsum   <= '0;
            r_bcount <= '0;
            r_msum   <= '0;
            r_ssum   <= '0;
            r_ovf    <= 1'b0;
            r_last   <= 1'b0;
        end
    end

    // Working values along the close and finish sequences
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= w_neg;
        end
        if (i_cmd.mul) begin
            r_prod <= r_mag * r_mag;
        end
        if (i_cmd.div_take) begin
            case (i_cmd.sel)
                SEL_SQ: begin
                    r_acc <= (w_quot > w_esq) ? (w_quot - w_esq) : '0;
                end
                SEL_VAR: begin
                    r_acc <= (w_quot > V_MAX) ? V_MAX : w_quot;
                end
                default: begin
                    r_m   <= w_clamp.m;
                    r_mag <= w_clamp.mag;
                end
            endcase
        end
        if (i_cmd.sqrt_take) begin
            r_std <= w_root[SQ_W/2-1] ? '1 : w_root[STD_W-1:0];
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_bcount == '0) begin
                r_omean <= '0;
                r_ostd  <= '0;
                r_oblk  <= '0;
                r_ostat <= ST_NOBLK;
            end else begin
                r_omean <= r_m;
                r_ostd  <= r_std;
                r_oblk  <= r_bcount;
                r_ostat <= r_ovf ? ST_OVF : ST_OK;
            end
        end
    end

    assign o_stat.close     = w_close;
    assign o_stat.last      = r_last;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.sqrt_done = w_sqrt_done;
    assign o_stat.no_blocks = (r_bcount == '0);
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid   = r_ovalid;
    assign o_mean        = r_omean;
    assign o_std_error   = r_ostd;
    assign o_blocks_used = r_oblk;
    assign o_status      = r_ostat;

endmodule
`default_nettype wire

### hdl/blocking_mean_std_error_core.sv
// A sample that leaves its block open is taken without holding the input; one that
// closes a block holds the input while a 64-step serial divide forms the block mean.
// A last sample then adds three 64-step divides and a 32-step root;
// with no full block it goes straight to the result. The input stays held until
// the result is loaded into the output register, so an output stall holds it too.
// Synchronous active-low reset clears all sums and sets the group length to 10.
`timescale 1ns / 1ps
`default_nettype none
module blocking_mean_std_error_core
    import bmse_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Sample channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_last,
    // Result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [SAMPLE_W-1:0]      o_mean,
    output logic [STD_W-1:0]         o_std_error,
    output logic [BLK_W-1:0]         o_blocks_used,
    output logic [1:0]               o_status,
    // Register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [1:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [SIZE_W-1:0] r_grp_len;
    t_cmd              w_cmd;
    t_stat             w_stat;

    // Block size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_len <= SIZE_W'(10);
        end else if (psel && penable && pwrite) begin
            r_grp_len <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata = (paddr == 2'd0) ? {16'd0, r_grp_len} : 32'd0;
    assign pready = 1'b1;

    bmse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    bmse_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .i_grp_len     (r_grp_len),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_mean        (o_mean),
        .o_std_error   (o_std_error),
        .o_blocks_used (o_blocks_used),
        .o_status      (o_status)
    );

endmodule
`default_nettype wire

### hdl/bmse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "blocking_mean_std_error_core_macros.svh"
module bmse_checker
    import bmse_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [SAMPLE_W-1:0] o_mean,
    input wire logic [STD_W-1:0]    o_std_error,
    input wire logic [BLK_W-1:0]    o_blocks_used,
    input wire logic [1:0]          o_status,
    input wire logic                pready
);

    logic w_stall;
    logic w_noblk;
    logic w_zero;
    logic w_blk_res;

    assign w_stall   = o_out_valid && !i_out_ready;
    assign w_noblk   = o_out_valid && (o_status == ST_NOBLK);
    assign w_zero    = (o_blocks_used == '0) && (o_mean == '0) && (o_std_error == '0);
    assign w_blk_res = o_out_valid && (o_status != ST_NOBLK);

    // Stalled result transaction holds its mean and status
    `BMSE_ASSERT_NXT(a_out_hold, w_stall, o_out_valid && $stable(o_mean) && $stable(o_status))

    // No-block result carries zero statistics
    `BMSE_ASSERT_IMP(a_noblk_zero, w_noblk, w_zero)

    // Any other result counts at least one block
    `BMSE_ASSERT_IMP(a_blk_nonzero, w_blk_res, o_blocks_used != '0)

    // Block count never exceeds the limit
    `BMSE_ASSERT_IMP(a_blk_limit, o_out_valid, o_blocks_used <= BLK_W'(MAX_BLOCKS))

    // Register port never stalls
    `BMSE_ASSERT_IMP(a_pready, 1'b1, pready)

endmodule

bind blocking_mean_std_error_core bmse_checker u_bmse_checker (.*);
`default_nettype wire
